[hw/rtl/fixed_point_goertzel_bin_defines.svh]
// Assertion macros for the checker file of this block.
`ifndef FIXED_POINT_GOERTZEL_BIN_DEFINES_SVH
`define FIXED_POINT_GOERTZEL_BIN_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define GZB_ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("goertzel bin check failed");

// Clocked property that is also evaluated during reset.
`define GZB_ASSERT_RAW(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("goertzel bin reset check failed");

`endif

[hw/rtl/gzb_pkg.sv]
package gzb_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int STATE_W      = 32;
  localparam int COUNT_W      = 16;
  localparam int PROD_W       = 2 * STATE_W;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [COUNT_W-1:0] BLOCK_LENGTH_RESET = COUNT_W'(128);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEF_COS     = 2'd0,
    REG_COEF_SIN     = 2'd1,
    REG_BLOCK_LENGTH = 2'd2
  } gzb_reg_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] coef_cos;
    logic signed [STATE_W-1:0] coef_sin;
    logic [COUNT_W-1:0]        block_length;
  } gzb_cfg_t;

  // Queue head as seen by the datapath.
  typedef struct packed {
    logic                      valid;
    logic signed [STATE_W-1:0] x;
  } gzb_item_t;

endpackage

[hw/rtl/gzb_if.sv]
interface gzb_in_if import gzb_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gzb_out_if import gzb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [STATE_W-1:0] real_part;
  logic signed [STATE_W-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink (input valid, input real_part, input imag_part, output ready);
endinterface

[hw/rtl/gzb_front.sv]
module gzb_front import gzb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gzb_in_if.sink      in_s,
  output gzb_item_t   head,
  input  logic        pop
);

  logic [SAMPLE_WIDTH-1:0] mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic                    push;
  logic                    do_pop;
  logic [SAMPLE_WIDTH-1:0] raw;

  assign in_s.ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign push       = in_s.valid && in_s.ready;
  assign do_pop     = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_s.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // The head sample is sign-extended to the state width here.
  assign raw        = mem_r[rd_ptr_r];
  assign head.valid = (count_r != '0);
  assign head.x     = {{(STATE_W - SAMPLE_WIDTH){raw[SAMPLE_WIDTH-1]}}, raw};

endmodule

[hw/rtl/gzb_back.sv]
module gzb_back import gzb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gzb_cfg_t    cfg,
  input  gzb_item_t   head,
  output logic        pop,
  gzb_out_if.source   out_s
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_END_COS,
    S_END_SIN,
    S_END_OUT
  } state_t;

  state_t                    state_r;
  logic signed [STATE_W-1:0] s1_r;
  logic signed [STATE_W-1:0] s2_r;
  logic [COUNT_W-1:0]        count_r;
  logic signed [STATE_W-1:0] x_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [STATE_W-1:0] re_r;
  logic                      out_valid_r;
  logic signed [STATE_W-1:0] out_real_r;
  logic signed [STATE_W-1:0] out_imag_r;

  logic signed [STATE_W-1:0] mul_a;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [STATE_W-1:0] s_nxt;
  logic [COUNT_W:0]          count_nxt;
  logic [COUNT_W-1:0]        len;
  logic                      block_end;
  logic                      out_free;
  logic                      out_load;

  // One shared multiplier; the sine coefficient is used only for the imaginary part.
  assign mul_a = (state_r == S_END_SIN) ? cfg.coef_sin : cfg.coef_cos;
  assign mul_p = mul_a * s1_r;

  assign s_nxt     = x_r + prod_r[STATE_W+29:30] - s2_r;
  assign count_nxt = {1'b0, count_r} + 1'b1;
  assign len       = (cfg.block_length == '0) ? COUNT_W'(1) : cfg.block_length;
  assign block_end = (count_nxt >= {1'b0, len});
  assign out_free  = !out_valid_r || out_s.ready;
  assign out_load  = (state_r == S_END_OUT) && out_free;
  assign pop       = (state_r == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s1_r        <= '0;
      s2_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_s.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            x_r     <= head.x;
            prod_r  <= mul_p;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          s2_r <= s1_r;
          s1_r <= s_nxt;
          if (block_end) begin
            state_r <= S_END_COS;
          end else begin
            count_r <= count_nxt[COUNT_W-1:0];
            state_r <= S_IDLE;
          end
        end
        S_END_COS: begin
          prod_r  <= mul_p;
          state_r <= S_END_SIN;
        end
        S_END_SIN: begin
          re_r    <= prod_r[STATE_W+30:31] - s2_r;
          prod_r  <= mul_p;
          state_r <= S_END_OUT;
        end
        S_END_OUT: begin
          if (out_free) begin
            out_real_r  <= re_r;
            out_imag_r  <= prod_r[STATE_W+30:31];
            s1_r        <= '0;
            s2_r        <= '0;
            count_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_s.valid     = out_valid_r;
  assign out_s.real_part = out_real_r;
  assign out_s.imag_part = out_imag_r;

endmodule

[hw/rtl/fixed_point_goertzel_bin.sv]
// Channel  | Dir | Payload                        | Transaction
// in_s     | in  | sample (16-bit signed)         | valid && ready
// out_s    | out | real_part, imag_part (32-bit)  | valid && ready
// cfg_*    | in  | cfg_index, cfg_wdata           | cfg_we high
//
// Each sample passes through S_IDLE, which takes it with the coefficient
// multiply, and S_ADD, which does the add that closes the recursion loop.
// A block end adds S_END_COS and S_END_SIN for the real and imaginary products,
// which share the single 32x32 multiplier, and S_END_OUT for the output load.
// Reset (synchronous, active low) clears the states, the count, the queue
// and the registers to their defaults; block_length resets to 128.
// While a result waits on out_s, the back end runs on to its next block end
// and the two-entry queue fills; after that in_s stalls until out_s drains.
module fixed_point_goertzel_bin import gzb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  gzb_in_if.sink                 in_s,
  gzb_out_if.source              out_s,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers, read directly by the datapath. The user writes them
  // only while the block is idle; the block does not enforce this. An index past the list is ignored.
  gzb_cfg_t  cfg_r;
  gzb_item_t head;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_cos     <= '0;
      cfg_r.coef_sin     <= '0;
      cfg_r.block_length <= BLOCK_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_COS:     cfg_r.coef_cos     <= cfg_wdata[STATE_W-1:0];
        REG_COEF_SIN:     cfg_r.coef_sin     <= cfg_wdata[STATE_W-1:0];
        REG_BLOCK_LENGTH: cfg_r.block_length <= cfg_wdata[COUNT_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // The front end accepts samples, sign-extends them and queues them.
  gzb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .head  (head),
    .pop   (pop)
  );

  // The back end runs the recursion and emits the bin at each block end.
  gzb_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .head  (head),
    .pop   (pop),
    .out_s (out_s)
  );

endmodule

[hw/rtl/gzb_checker.sv]
`include "fixed_point_goertzel_bin_defines.svh"

module gzb_checker import gzb_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STATE_W-1:0] out_real,
  input logic [STATE_W-1:0] out_imag
);

  // Samples accepted minus results taken; a result needs a sample behind it.
  logic [STATE_W-1:0] credit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   credit_r <= credit_r + 1'b1;
        2'b01:   credit_r <= credit_r - 1'b1;
        default: credit_r <= credit_r;
      endcase
    end
  end

  `GZB_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag))
  `GZB_ASSERT_CLK(a_result_has_sample, out_valid |-> credit_r != '0)
  `GZB_ASSERT_RAW(a_reset_state, !rst_n |=> in_ready && !out_valid)

endmodule

bind fixed_point_goertzel_bin gzb_checker u_gzb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_real  (out_s.real_part),
  .out_imag  (out_s.imag_part)
);

[bench/fixed_point_goertzel_bin_tb.sv]
module fixed_point_goertzel_bin_tb;
  import gzb_pkg::*;

  // Run-length knobs. The tail covers the samples that may still sit in the
  // block's two-entry queue, plus the block-end products.
  localparam int          RANDOM_ITEMS     = 2000;
  localparam int          TAIL_CYCLES      = 12;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          HOLD_BURST_ITEMS = 40;
  localparam longint      TIMEOUT_CYCLES   = 500000;

  // The register map decodes two index bits but only uses three codes.
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_UNUSED = 2'd3;

  // One bin value as the block reports it at the end of a block.
  typedef struct packed {
    logic signed [STATE_W-1:0] real_part;
    logic signed [STATE_W-1:0] imag_part;
  } bin_result_t;

  logic clk;
  logic rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  gzb_in_if  in_if ();
  gzb_out_if out_if ();

  fixed_point_goertzel_bin dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Samples waiting for the driver, and bin values waiting for the block.
  logic [SAMPLE_WIDTH-1:0] pending_samples[$];
  bin_result_t             expected_bins[$];
  int                      errors = 0;

  // Controls set by the stimulus process and read by the driver and sink.
  logic src_idle_on;
  logic snk_idle_on;
  logic long_hold_req;
  logic long_hold_done;

  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_count;

  // Predictor copy of the configuration and of the recursion state.
  logic signed [STATE_W-1:0] cos_coef;
  logic signed [STATE_W-1:0] sin_coef;
  logic [COUNT_W-1:0]        bin_block_len;
  logic [STATE_W-1:0]        goertzel_s1;
  logic [STATE_W-1:0]        goertzel_s2;
  logic [COUNT_W:0]          samples_in_block;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("DONE: errors detected");
    $finish;
  end

  // Bits [shift+31:shift] of the exact signed product, as the block's
  // multiplier delivers them after the arithmetic shift.
  function automatic logic [STATE_W-1:0] product_slice(
    input logic signed [STATE_W-1:0] a,
    input logic signed [STATE_W-1:0] b,
    input int unsigned               shift
  );
    logic signed [PROD_W-1:0] wide_a;
    logic signed [PROD_W-1:0] wide_b;
    logic signed [PROD_W-1:0] full;
    wide_a = a;
    wide_b = b;
    full = wide_a * wide_b;
    full = full >>> shift;
    return full[STATE_W-1:0];
  endfunction

  // Advance the recursion by one sample and queue the bin value when the
  // block completes. A zero length behaves as a length of one, and a length
  // lowered under the running count closes the block on this sample.
  function automatic void goertzel_step(input logic [SAMPLE_WIDTH-1:0] x);
    logic [STATE_W-1:0] x_ext;
    logic [STATE_W-1:0] s_next;
    logic [COUNT_W:0]   limit;
    bin_result_t        bin;
    x_ext = {{(STATE_W - SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
    s_next = x_ext + product_slice(cos_coef, goertzel_s1, 30) - goertzel_s2;
    limit = (bin_block_len == '0) ? (COUNT_W + 1)'(1) : {1'b0, bin_block_len};
    goertzel_s2 = goertzel_s1;
    goertzel_s1 = s_next;
    samples_in_block = samples_in_block + 1'b1;
    if (samples_in_block >= limit) begin
      bin.real_part = product_slice(cos_coef, goertzel_s1, 31) - goertzel_s2;
      bin.imag_part = product_slice(sin_coef, goertzel_s1, 31);
      expected_bins.push_back(bin);
      goertzel_s1 = '0;
      goertzel_s2 = '0;
      samples_in_block = '0;
    end
  endfunction

  // Register writes land in the predictor at the same edge as in the block.
  // The upper data bits of the length write are dropped by the block.
  function automatic void apply_register(
    input logic [CFG_INDEX_W-1:0] idx,
    input logic [CFG_DATA_W-1:0]  data
  );
    case (idx)
      REG_COEF_COS:     cos_coef = data;
      REG_COEF_SIN:     sin_coef = data;
      REG_BLOCK_LENGTH: bin_block_len = data[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Sample driver. A transaction leaves the head of the queue; between
  // transactions it may insert an idle gap drawn per item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= '0;
      gap_left     <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        in_if.valid  <= 1'b1;
        in_if.sample <= pending_samples.pop_front();
        gap_left     <= src_idle_on ? $urandom_range(0, 5) : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink. After each transaction it may drop ready for a drawn number
  // of cycles. On request it also holds off for a long stretch so that the
  // block's queue fills and the input channel backs up.
  always @(posedge clk) begin : result_sink
    int unsigned wait_draw;
    if (!rst_n) begin
      out_if.ready   <= 1'b0;
      stall_left     <= 0;
      hold_count     <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      out_if.ready <= 1'b0;
      hold_count   <= hold_count + 1;
      if (hold_count == LONG_HOLD_CYCLES)
        long_hold_done <= 1'b1;
    end else if (out_if.valid && out_if.ready) begin
      wait_draw = snk_idle_on ? $urandom_range(0, 5) : 0;
      stall_left   <= wait_draw;
      out_if.ready <= (wait_draw == 0);
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor. Checks each result transaction against the oldest expected bin
  // value first, then feeds register writes and accepted samples to the
  // predictor. A result can never leave in the cycle its last sample enters,
  // so this order is safe.
  always @(posedge clk) begin : bin_monitor
    bin_result_t want;
    if (!rst_n) begin
      cos_coef         = '0;
      sin_coef         = '0;
      bin_block_len    = BLOCK_LENGTH_RESET;
      goertzel_s1      = '0;
      goertzel_s2      = '0;
      samples_in_block = '0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_bins.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual real %0d imag %0d",
                   $time, out_if.real_part, out_if.imag_part);
        end else begin
          want = expected_bins.pop_front();
          if (out_if.real_part !== want.real_part) begin
            errors++;
            $display("%0t: real_part mismatch, expected %0d, actual %0d",
                     $time, want.real_part, out_if.real_part);
          end
          if (out_if.imag_part !== want.imag_part) begin
            errors++;
            $display("%0t: imag_part mismatch, expected %0d, actual %0d",
                     $time, want.imag_part, out_if.imag_part);
          end
        end
      end
      if (cfg_we)
        apply_register(cfg_index, cfg_wdata);
      if (in_if.valid && in_if.ready)
        goertzel_step(in_if.sample);
    end
  end

  // One register write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0]  data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued sample went in and every bin value came out.
  // Samples that close no block may still be in flight, hence the tail.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_if.valid || expected_bins.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
      2:       return '0;
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [STATE_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return 32'h4000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly short blocks so that results are frequent; now and then a zero,
  // the reset length, a longer block, or the largest length, which a later
  // shorter length then cuts off.
  function automatic logic [COUNT_W-1:0] pick_block_len();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return BLOCK_LENGTH_RESET;
      3, 4:    return COUNT_W'($urandom_range(17, 300));
      default: return COUNT_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic pick_idling();
    logic [1:0] mode;
    mode = 2'($urandom_range(0, 3));
    @(posedge clk);
    src_idle_on <= mode[0];
    snk_idle_on <= mode[1];
  endtask

  initial begin : stimulus
    int                 random_sent;
    int                 phase_items;
    logic [STATE_W-1:0] upper_noise;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    src_idle_on   = 1'b1;
    snk_idle_on   = 1'b1;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Largest coefficients with a block of one: every sample yields a bin
    // value, and the products push the sums through wraparound.
    write_reg(REG_COEF_COS, 32'h7FFF_FFFF);
    write_reg(REG_COEF_SIN, 32'h8000_0000);
    write_reg(REG_BLOCK_LENGTH, 32'd1);
    pending_samples = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    wait_idle();

    // A zero block length acts as a length of one.
    write_reg(REG_BLOCK_LENGTH, 32'hABCD_0000);
    pending_samples = '{16'h8000, 16'h7FFF, 16'h3039};
    wait_idle();

    // Opposite coefficient extremes with full-scale samples, two blocks.
    write_reg(REG_COEF_COS, 32'h8000_0000);
    write_reg(REG_COEF_SIN, 32'h7FFF_FFFF);
    write_reg(REG_BLOCK_LENGTH, 32'd4);
    pending_samples = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                        16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    wait_idle();

    // Start a block of the largest length, then shorten it below the count
    // already reached: the next sample has to close the block.
    write_reg(REG_COEF_COS, 32'h5A82_799A);
    write_reg(REG_COEF_SIN, 32'h5A82_799A);
    write_reg(REG_BLOCK_LENGTH, 32'h0000_FFFF);
    pending_samples = '{16'd1000, -16'sd2000, 16'd3000};
    wait_idle();
    write_reg(REG_BLOCK_LENGTH, 32'd2);
    pending_samples = '{16'd7};
    wait_idle();

    // A write to the unused index must change nothing. Then a coefficient
    // changes halfway through a block without clearing the states.
    write_reg(REG_INDEX_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_BLOCK_LENGTH, 32'd5);
    pending_samples = '{16'h1234, 16'hEDCB, 16'h4000};
    wait_idle();
    write_reg(REG_COEF_COS, 32'h4000_0000);
    pending_samples = '{16'hC000, 16'h0100};
    wait_idle();

    // Back-pressure: the sink holds off for a long stretch while the driver
    // keeps offering samples, so the block's queue fills and in_s stalls.
    write_reg(REG_BLOCK_LENGTH, 32'd1);
    @(posedge clk);
    long_hold_req <= 1'b1;
    repeat (HOLD_BURST_ITEMS) pending_samples.push_back(pick_sample());
    while (!long_hold_done) @(posedge clk);
    wait_idle();

    // Random phases. Each one may rewrite any register while the block is
    // idle, picks how both sides idle, and sends a burst of samples. States
    // carry over between phases, so many writes land mid-block.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1))
        write_reg(REG_COEF_COS, pick_coef());
      if ($urandom_range(0, 1))
        write_reg(REG_COEF_SIN, pick_coef());
      if ($urandom_range(0, 1)) begin
        upper_noise = $urandom();
        write_reg(REG_BLOCK_LENGTH, {upper_noise[STATE_W-1:COUNT_W], pick_block_len()});
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(REG_INDEX_UNUSED, $urandom());
      pick_idling();
      phase_items = $urandom_range(40, 160);
      repeat (phase_items) pending_samples.push_back(pick_sample());
      random_sent += phase_items;
      wait_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
